>>> hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Opcodes, control characters, sequencer states and field widths used by the
// console writer, its checker and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int OPCODE_W = 3;
   localparam int BYTE_W   = 8;
   localparam int CELL_W   = 16;
   localparam int OUT_ROW_W = 5;
   localparam int OUT_COL_W = 7;

   localparam logic [OPCODE_W-1:0] OP_PRINT      = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PRINT_ATTR = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SET_CURSOR = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_CELL  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd4;

   localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;

   localparam logic [BYTE_W-1:0] TEXT_ATTR_RESET = 8'h07;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_READ_WAIT,
      ST_DIVIDE,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_PRINT,
      ST_TAB_MOD,
      ST_PUT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PUT_SINGLE,
      PUT_LINE,
      PUT_TAB
   } put_kind_type;

endpackage

`default_nettype wire

>>> hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character and attribute screen with a cursor, scroll, clear and cell read.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall opcode, char, attr, row, col
//   rsp      out        rsp_valid/rsp_stall cursor row/col, scrolled, cell
//   csr      in         csr_wr_en           print attribute
//
// One request at a time. A scroll moves the screen up a row with a read and a
// write per moved cell, then clears the last row. After reset the memory is
// cleared. A stalled response holds; the next request waits in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25,
   parameter int TAB_CELLS   = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [OPCODE_W-1:0]  req_opcode,
   input  wire logic [BYTE_W-1:0]    req_char_code,
   input  wire logic [BYTE_W-1:0]    req_attr,
   input  wire logic [BYTE_W-1:0]    req_target_row,
   input  wire logic [BYTE_W-1:0]    req_target_col,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [OUT_ROW_W-1:0] rsp_cursor_row,
   output logic      [OUT_COL_W-1:0] rsp_cursor_col,
   output logic                      rsp_scrolled,
   output logic      [BYTE_W-1:0]    rsp_cell_char,
   output logic      [BYTE_W-1:0]    rsp_cell_attr,
   input  wire logic                 csr_wr_en,
   input  wire logic [BYTE_W-1:0]    csr_wr_data
);

   localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
   localparam int IDX_W      = $clog2(CELL_COUNT + 1);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(SCREEN_ROWS);
   localparam int COL_W      = $clog2(SCREEN_COLS + 1);
   localparam int TAB_W      = $clog2(TAB_CELLS);
   localparam int MUL_W      = 18;
   localparam int CMP_W      = 9;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     cnt_ff, cnt_in;
   logic                  init_ff, init_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic [BYTE_W-1:0]     ch_ff, ch_in;
   logic [BYTE_W-1:0]     at_ff, at_in;
   logic [BYTE_W-1:0]     trow_ff, trow_in;
   logic [BYTE_W-1:0]     tcol_ff, tcol_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [IDX_W-1:0]      wrk_ff, wrk_in;
   logic [TAB_W-1:0]      phase_ff, phase_in;
   put_kind_type          kind_ff, kind_in;
   logic                  scrolled_ff, scrolled_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;
   logic [BYTE_W-1:0]     text_attr_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [OUT_COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic                  rsp_scr_ff, rsp_scr_in;
   logic [CELL_W-1:0]     rsp_cell_ff, rsp_cell_in;

   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [CELL_W-1:0]     mem_wr_data;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [CELL_W-1:0]     mem_rd_data;

   logic [IDX_W-1:0]      sub_a, sub_b, sub_diff;
   logic                  sub_ge;

   logic                  accept;
   logic                  out_free;
   logic [MUL_W-1:0]      lin_idx;
   logic [IDX_W-1:0]      sat_idx;
   logic                  rd_in_range;
   logic                  at_end;
   logic                  is_print;
   logic [BYTE_W-1:0]     print_at;
   logic [COL_W-1:0]      col_nx;
   logic [TAB_W-1:0]      phase_nx;
   logic                  put_done;
   logic                  div_done;
   logic                  clr_done;
   logic                  copy_done;

   tcw_screen_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W),
      .DATA_W (CELL_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tcw_sub_unit #(
      .WIDTH (IDX_W)
   ) u_sub (
      .op_a   (sub_a),
      .op_b   (sub_b),
      .diff   (sub_diff),
      .a_ge_b (sub_ge)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared condition logic
   always_comb begin
      lin_idx = MUL_W'(trow_ff) * MUL_W'(SCREEN_COLS) + MUL_W'(tcol_ff);
      if (lin_idx > MUL_W'(CELL_COUNT)) begin
         sat_idx = IDX_W'(CELL_COUNT);
      end else begin
         sat_idx = lin_idx[IDX_W-1:0];
      end
      rd_in_range = ({1'b0, trow_ff} < CMP_W'(SCREEN_ROWS)) &&
                    ({1'b0, tcol_ff} < CMP_W'(SCREEN_COLS));
      at_end   = (addr_ff == IDX_W'(CELL_COUNT));
      is_print = (op_ff == OP_PRINT) || (op_ff == OP_PRINT_ATTR);
      print_at = (op_ff == OP_PRINT) ? text_attr_ff : at_ff;
      col_nx   = col_ff + 1'b1;
      phase_nx = (phase_ff == TAB_W'(TAB_CELLS - 1)) ? '0 : phase_ff + 1'b1;
      unique case (kind_ff)
         PUT_SINGLE: put_done = 1'b1;
         PUT_LINE:   put_done = (col_nx == COL_W'(SCREEN_COLS));
         PUT_TAB:    put_done = (col_nx == COL_W'(SCREEN_COLS)) || (phase_nx == '0);
         default:    put_done = 1'b1;
      endcase
      div_done  = !sub_ge || (row_ff == ROW_W'(SCREEN_ROWS - 1));
      clr_done  = (cnt_ff == ADDR_W'(CELL_COUNT - 1));
      copy_done = (cnt_ff == ADDR_W'(CELL_COUNT - SCREEN_COLS - 1));
   end

   // shared unit operands
   always_comb begin
      unique case (state_ff)
         ST_DIVIDE: begin
            sub_a = wrk_ff;
            sub_b = IDX_W'(SCREEN_COLS);
         end
         ST_TAB_MOD: begin
            sub_a = wrk_ff;
            sub_b = IDX_W'(TAB_CELLS);
         end
         default: begin
            sub_a = addr_ff;
            sub_b = IDX_W'(col_ff);
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               if (init_ff) begin
                  state_in = ST_IDLE;
               end else if (is_print) begin
                  state_in = ST_PRINT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (op_ff)
               OP_PRINT, OP_PRINT_ATTR: state_in = at_end ? ST_SCROLL_RD : ST_PRINT;
               OP_SET_CURSOR:           state_in = ST_DIVIDE;
               OP_READ_CELL:            state_in = rd_in_range ? ST_READ_WAIT : ST_FINISH;
               OP_CLEAR:                state_in = ST_CLEAR;
               default:                 state_in = ST_FINISH;
            endcase
         end
         ST_READ_WAIT: state_in = ST_FINISH;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCROLL_RD: state_in = ST_SCROLL_WR;
         ST_SCROLL_WR: state_in = copy_done ? ST_CLEAR : ST_SCROLL_RD;
         ST_PRINT: begin
            priority if (ch_ff == CHAR_NEWLINE) begin
               state_in = ST_PUT;
            end else if (ch_ff == CHAR_TAB) begin
               state_in = ST_TAB_MOD;
            end else if (ch_ff == CHAR_RETURN || ch_ff == CHAR_BACKSPACE) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_TAB_MOD: begin
            if (!sub_ge) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (put_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      cnt_in      = cnt_ff;
      init_in     = init_ff;
      op_in       = op_ff;
      ch_in       = ch_ff;
      at_in       = at_ff;
      trow_in     = trow_ff;
      tcol_in     = tcol_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      addr_in     = addr_ff;
      wrk_in      = wrk_ff;
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      scrolled_in = scrolled_ff;
      cell_in     = cell_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cnt_ff;
      mem_wr_data = '0;
      mem_rd_addr = cnt_ff + ADDR_W'(SCREEN_COLS);

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_scr_in   = rsp_scr_ff;
      rsp_cell_in  = rsp_cell_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (clr_done) begin
               init_in = 1'b0;
               if (is_print && !init_ff) begin
                  row_in  = ROW_W'(SCREEN_ROWS - 1);
                  col_in  = '0;
                  addr_in = IDX_W'(CELL_COUNT - SCREEN_COLS);
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               ch_in       = req_char_code;
               at_in       = req_attr;
               trow_in     = req_target_row;
               tcol_in     = req_target_col;
               scrolled_in = 1'b0;
               cell_in     = '0;
            end
         end
         ST_DISPATCH: begin
            mem_rd_addr = ADDR_W'(lin_idx);
            unique case (op_ff)
               OP_PRINT, OP_PRINT_ATTR: begin
                  if (at_end) begin
                     cnt_in      = '0;
                     scrolled_in = 1'b1;
                  end
               end
               OP_SET_CURSOR: begin
                  wrk_in  = sat_idx;
                  addr_in = sat_idx;
                  row_in  = '0;
               end
               OP_CLEAR: begin
                  cnt_in  = '0;
                  row_in  = '0;
                  col_in  = '0;
                  addr_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_READ_WAIT: begin
            cell_in = mem_rd_data;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               col_in = COL_W'(wrk_ff);
            end else begin
               wrk_in = sub_diff;
               row_in = row_ff + 1'b1;
            end
         end
         ST_SCROLL_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data;
            cnt_in      = cnt_ff + 1'b1;
         end
         ST_PRINT: begin
            priority if (ch_ff == CHAR_NEWLINE) begin
               kind_in = PUT_LINE;
            end else if (ch_ff == CHAR_TAB) begin
               kind_in = PUT_TAB;
               wrk_in  = IDX_W'(col_ff);
            end else if (ch_ff == CHAR_RETURN) begin
               addr_in = sub_diff;
               col_in  = '0;
            end else if (ch_ff == CHAR_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_in  = col_ff - 1'b1;
                  addr_in = addr_ff - 1'b1;
               end
            end else begin
               kind_in = PUT_SINGLE;
            end
         end
         ST_TAB_MOD: begin
            if (sub_ge) begin
               wrk_in = sub_diff;
            end else begin
               phase_in = TAB_W'(wrk_ff);
            end
         end
         ST_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ADDR_W'(addr_ff);
            mem_wr_data = {print_at, (kind_ff == PUT_SINGLE) ? ch_ff : CHAR_SPACE};
            addr_in     = addr_ff + 1'b1;
            phase_in    = phase_nx;
            if ((col_nx == COL_W'(SCREEN_COLS)) && (row_ff != ROW_W'(SCREEN_ROWS - 1))) begin
               row_in = row_ff + 1'b1;
               col_in = '0;
            end else begin
               col_in = col_nx;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = OUT_ROW_W'(row_ff);
               rsp_col_in   = OUT_COL_W'(col_ff);
               rsp_scr_in   = scrolled_ff;
               rsp_cell_in  = cell_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         init_ff      <= 1'b1;
         row_ff       <= '0;
         col_ff       <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         text_attr_ff <= TEXT_ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            text_attr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      at_ff       <= at_in;
      trow_ff     <= trow_in;
      tcol_ff     <= tcol_in;
      wrk_ff      <= wrk_in;
      phase_ff    <= phase_in;
      kind_ff     <= kind_in;
      scrolled_ff <= scrolled_in;
      cell_ff     <= cell_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_scr_ff  <= rsp_scr_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scr_ff;
   assign rsp_cell_char  = rsp_cell_ff[BYTE_W-1:0];
   assign rsp_cell_attr  = rsp_cell_ff[CELL_W-1:BYTE_W];

endmodule

`default_nettype wire

>>> hdl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/tcw_sub_unit.sv
// ----------------------------------------------------------------------------
// Shared subtract and compare unit
// Gives a - b and whether a is at least b; reused for row division,
// tab phase and carriage return.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_sub_unit #(
   parameter int WIDTH = 12
) (
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   output logic      [WIDTH-1:0] diff,
   output logic                  a_ge_b
);

   logic [WIDTH:0] full;

   assign full   = {1'b0, op_a} - {1'b0, op_b};
   assign diff   = full[WIDTH-1:0];
   assign a_ge_b = ~full[WIDTH];

endmodule

`default_nettype wire

>>> sim/console_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console writer checker
// Watches the request, response and attribute ports of the console writer. It
// keeps its own copy of the screen, the cursor and the print attribute, works
// out the response of every accepted request, and compares each accepted
// response field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------

module console_checker
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25,
   parameter int TAB_CELLS   = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic [BYTE_W-1:0]    req_char_code,
   input  logic [BYTE_W-1:0]    req_attr,
   input  logic [BYTE_W-1:0]    req_target_row,
   input  logic [BYTE_W-1:0]    req_target_col,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [OUT_ROW_W-1:0] rsp_cursor_row,
   input  logic [OUT_COL_W-1:0] rsp_cursor_col,
   input  logic                 rsp_scrolled,
   input  logic [BYTE_W-1:0]    rsp_cell_char,
   input  logic [BYTE_W-1:0]    rsp_cell_attr,
   input  logic                 csr_wr_en,
   input  logic [BYTE_W-1:0]    csr_wr_data,
   output int                   mismatch_count,
   output int                   pending_count,
   output int                   response_count,
   output int                   scroll_count
);

   localparam int CELL_COUNT   = SCREEN_ROWS * SCREEN_COLS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] cursor_row;
      logic [OUT_COL_W-1:0] cursor_col;
      logic                 scrolled;
      logic [BYTE_W-1:0]    cell_char;
      logic [BYTE_W-1:0]    cell_attr;
   } console_rsp_type;

   logic [CELL_W-1:0] screen_copy [CELL_COUNT];
   int                cursor_pos;
   logic [BYTE_W-1:0] print_attr;
   console_rsp_type   expected_rsp [$];
   int                mismatches;
   int                responses_seen;
   int                scrolls_seen;

   function automatic void put_cell(int idx, logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] at);
      if (idx < CELL_COUNT) screen_copy[idx] = {at, ch};
   endfunction

   function automatic logic print_char(logic [BYTE_W-1:0] ch, logic [BYTE_W-1:0] at);
      logic did_scroll;
      int   row;
      int   col;
      did_scroll = 1'b0;
      if (cursor_pos >= CELL_COUNT) begin
         for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
            screen_copy[i] = screen_copy[i + SCREEN_COLS];
         for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
            screen_copy[i] = '0;
         cursor_pos = CELL_COUNT - SCREEN_COLS;
         did_scroll = 1'b1;
      end
      row = cursor_pos / SCREEN_COLS;
      col = cursor_pos % SCREEN_COLS;
      case (ch)
         CHAR_NEWLINE: begin
            while (cursor_pos < (row + 1) * SCREEN_COLS) begin
               put_cell(cursor_pos, CHAR_SPACE, at);
               cursor_pos++;
            end
         end
         CHAR_RETURN: begin
            cursor_pos = row * SCREEN_COLS;
         end
         CHAR_BACKSPACE: begin
            cursor_pos = row * SCREEN_COLS + (col > 0 ? col - 1 : 0);
         end
         CHAR_TAB: begin
            do begin
               put_cell(cursor_pos, CHAR_SPACE, at);
               cursor_pos++;
               col++;
            end while (col < SCREEN_COLS && (col % TAB_CELLS) != 0);
         end
         default: begin
            put_cell(cursor_pos, ch, at);
            cursor_pos++;
         end
      endcase
      return did_scroll;
   endfunction

   function automatic console_rsp_type predict_console(logic [OPCODE_W-1:0] op,
                                                       logic [BYTE_W-1:0] ch,
                                                       logic [BYTE_W-1:0] at,
                                                       logic [BYTE_W-1:0] trow,
                                                       logic [BYTE_W-1:0] tcol);
      console_rsp_type r;
      int              idx;
      r = '0;
      case (op)
         OP_PRINT: begin
            r.scrolled = print_char(ch, print_attr);
         end
         OP_PRINT_ATTR: begin
            r.scrolled = print_char(ch, at);
         end
         OP_SET_CURSOR: begin
            idx = int'(trow) * SCREEN_COLS + int'(tcol);
            cursor_pos = idx > CELL_COUNT ? CELL_COUNT : idx;
         end
         OP_READ_CELL: begin
            if (int'(trow) < SCREEN_ROWS && int'(tcol) < SCREEN_COLS)
               {r.cell_attr, r.cell_char} = screen_copy[int'(trow) * SCREEN_COLS + int'(tcol)];
         end
         OP_CLEAR: begin
            foreach (screen_copy[i]) screen_copy[i] = '0;
            cursor_pos = 0;
         end
         default: begin
         end
      endcase
      if (cursor_pos >= CELL_COUNT) begin
         r.cursor_row = OUT_ROW_W'(SCREEN_ROWS - 1);
         r.cursor_col = OUT_COL_W'(SCREEN_COLS);
      end else begin
         r.cursor_row = OUT_ROW_W'(cursor_pos / SCREEN_COLS);
         r.cursor_col = OUT_COL_W'(cursor_pos % SCREEN_COLS);
      end
      return r;
   endfunction

   task automatic check_response();
      console_rsp_type want;
      console_rsp_type got;
      got.cursor_row = rsp_cursor_row;
      got.cursor_col = rsp_cursor_col;
      got.scrolled   = rsp_scrolled;
      got.cell_char  = rsp_cell_char;
      got.cell_attr  = rsp_cell_attr;
      responses_seen++;
      if (expected_rsp.size() == 0) begin
         if (mismatches < REPORT_LIMIT)
            $display("%0t: response with no request waiting: row %0d col %0d scrolled %0d",
                     $time, got.cursor_row, got.cursor_col, got.scrolled);
         mismatches++;
      end else begin
         want = expected_rsp.pop_front();
         if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
             got.scrolled !== want.scrolled || got.cell_char !== want.cell_char ||
             got.cell_attr !== want.cell_attr) begin
            if (mismatches < REPORT_LIMIT) begin
               $display("%0t: response %0d expected row %0d col %0d scrolled %0d char %02h attr %02h",
                        $time, responses_seen, want.cursor_row, want.cursor_col,
                        want.scrolled, want.cell_char, want.cell_attr);
               $display("%0t: response %0d actual   row %0d col %0d scrolled %0d char %02h attr %02h",
                        $time, responses_seen, got.cursor_row, got.cursor_col,
                        got.scrolled, got.cell_char, got.cell_attr);
            end
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      console_rsp_type next_rsp;
      if (reset) begin
         foreach (screen_copy[i]) screen_copy[i] = '0;
         cursor_pos = 0;
         print_attr = TEXT_ATTR_RESET;
         expected_rsp.delete();
      end else begin
         if (csr_wr_en) print_attr = csr_wr_data;
         if (rsp_valid && !rsp_stall) check_response();
         if (req_valid && !req_stall) begin
            next_rsp = predict_console(req_opcode, req_char_code, req_attr,
                                       req_target_row, req_target_col);
            if (next_rsp.scrolled) scrolls_seen++;
            expected_rsp.push_back(next_rsp);
         end
      end
      pending_count  <= expected_rsp.size();
      mismatch_count <= mismatches;
      response_count <= responses_seen;
      scroll_count   <= scrolls_seen;
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Console writer testbench
// Drives print, attribute print, cursor, cell read, clear and unused opcode
// requests into the console writer, first a directed set around control
// characters, scrolling and range limits, then random requests over several
// print attribute values, with random gaps and response stalls on both sides except in one steady phase.
// ----------------------------------------------------------------------------

module testbench;
   import tcw_pkg::*;

   localparam int SCREEN_COLS      = 80;
   localparam int SCREEN_ROWS      = 25;
   localparam int TAB_CELLS        = 8;
   localparam int PHASES           = 6;
   localparam int ITEMS_PER_PHASE  = 320;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 50;
   localparam int CYCLE_LIMIT      = 50_000_000;

   localparam logic [OPCODE_W-1:0] OPCODE_MAX = '1;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [BYTE_W-1:0]   char_code;
      logic [BYTE_W-1:0]   attr;
      logic [BYTE_W-1:0]   target_row;
      logic [BYTE_W-1:0]   target_col;
   } console_req_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [OPCODE_W-1:0]  req_opcode     = '0;
   logic [BYTE_W-1:0]    req_char_code  = '0;
   logic [BYTE_W-1:0]    req_attr       = '0;
   logic [BYTE_W-1:0]    req_target_row = '0;
   logic [BYTE_W-1:0]    req_target_col = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [OUT_ROW_W-1:0] rsp_cursor_row;
   logic [OUT_COL_W-1:0] rsp_cursor_col;
   logic                 rsp_scrolled;
   logic [BYTE_W-1:0]    rsp_cell_char;
   logic [BYTE_W-1:0]    rsp_cell_attr;
   logic                 csr_wr_en      = 1'b0;
   logic [BYTE_W-1:0]    csr_wr_data    = '0;

   int   mismatch_count;
   int   pending_count;
   int   response_count;
   int   scroll_count;
   int   requests_sent   = 0;
   int   cycle_count     = 0;
   logic steady_phase    = 1'b0;
   logic long_hold_armed = 1'b0;

   always #5 clock = ~clock;

   text_console_writer #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS),
      .TAB_CELLS   (TAB_CELLS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_attr       (req_attr),
      .req_target_row (req_target_row),
      .req_target_col (req_target_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   console_checker #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS),
      .TAB_CELLS   (TAB_CELLS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_attr       (req_attr),
      .req_target_row (req_target_row),
      .req_target_col (req_target_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .response_count (response_count),
      .scroll_count   (scroll_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("text_console_writer test failed");
         $finish;
      end
   end

   function automatic console_req_type make_request(logic [OPCODE_W-1:0] op,
                                                    logic [BYTE_W-1:0] ch,
                                                    logic [BYTE_W-1:0] at,
                                                    logic [BYTE_W-1:0] row,
                                                    logic [BYTE_W-1:0] col);
      console_req_type r;
      r.opcode     = op;
      r.char_code  = ch;
      r.attr       = at;
      r.target_row = row;
      r.target_col = col;
      return r;
   endfunction

   function automatic console_req_type random_request();
      console_req_type r;
      int              pick;
      r.char_code  = BYTE_W'($urandom_range(0, 255));
      r.attr       = BYTE_W'($urandom_range(0, 255));
      r.target_row = BYTE_W'($urandom_range(0, 255));
      r.target_col = BYTE_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 999);
      if (pick < 450)      r.opcode = OP_PRINT;
      else if (pick < 700) r.opcode = OP_PRINT_ATTR;
      else if (pick < 820) r.opcode = OP_SET_CURSOR;
      else if (pick < 970) r.opcode = OP_READ_CELL;
      else if (pick < 980) r.opcode = OP_CLEAR;
      else                 r.opcode = OPCODE_W'($urandom_range(OP_CLEAR + 1, OPCODE_MAX));
      pick = $urandom_range(0, 99);
      if (pick < 6)       r.char_code = CHAR_NEWLINE;
      else if (pick < 11) r.char_code = CHAR_TAB;
      else if (pick < 14) r.char_code = CHAR_RETURN;
      else if (pick < 17) r.char_code = CHAR_BACKSPACE;
      // keep most cursor moves and reads on screen; the rest land anywhere
      if ($urandom_range(0, 99) < 85) begin
         r.target_row = BYTE_W'($urandom_range(0, SCREEN_ROWS - 1));
         r.target_col = BYTE_W'($urandom_range(0, SCREEN_COLS - 1));
      end
      return r;
   endfunction

   function automatic int sender_gap();
      int pick;
      if (steady_phase) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 20);
      return $urandom_range(40, 150);
   endfunction

   task automatic send_request(input console_req_type r);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= r.opcode;
      req_char_code  <= r.char_code;
      req_attr       <= r.attr;
      req_target_row <= r.target_row;
      req_target_col <= r.target_col;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_text_attr(input logic [BYTE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : receiver
      int pick;
      forever begin
         @(posedge clock);
         if (long_hold_armed) begin
            // hold off long enough for the request side to back up
            long_hold_armed = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (steady_phase) begin
            rsp_stall <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(0, 30)) @(posedge clock);
            end else if (pick < 95) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(0, 3)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(20, 120)) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] next_attr;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request(OP_PRINT, "A", 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT_ATTR, "B", 8'hFF, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT_ATTR, 8'h00, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT_ATTR, 8'hFF, 8'hA5, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT, CHAR_TAB, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT, CHAR_BACKSPACE, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT, CHAR_RETURN, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT, CHAR_BACKSPACE, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT_ATTR, CHAR_NEWLINE, 8'h5A, 8'd0, 8'd0));
      send_request(make_request(OP_SET_CURSOR, 8'h00, 8'h00, 8'd5, 8'd79));
      send_request(make_request(OP_PRINT, CHAR_TAB, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_SET_CURSOR, 8'h00, 8'h00, 8'd24, 8'd79));
      send_request(make_request(OP_PRINT, "z", 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_PRINT_ATTR, "y", 8'h3C, 8'd0, 8'd0));
      send_request(make_request(OP_SET_CURSOR, 8'h00, 8'h00, 8'd255, 8'd255));
      send_request(make_request(OP_PRINT, CHAR_NEWLINE, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_SET_CURSOR, 8'h00, 8'h00, 8'd24, 8'd80));
      send_request(make_request(OP_PRINT, CHAR_RETURN, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_READ_CELL, 8'h00, 8'h00, 8'd23, 8'd79));
      send_request(make_request(OP_READ_CELL, 8'h00, 8'h00, 8'd25, 8'd0));
      send_request(make_request(OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd80));
      send_request(make_request(OP_READ_CELL, 8'hFF, 8'hFF, 8'd255, 8'd255));
      send_request(make_request(OP_SET_CURSOR, 8'h00, 8'h00, 8'd0, 8'd255));
      for (int u = OP_CLEAR + 1; u <= OPCODE_MAX; u++)
         send_request(make_request(OPCODE_W'(u), 8'hFF, 8'hFF, 8'd3, 8'd3));
      send_request(make_request(OP_CLEAR, 8'h00, 8'h00, 8'd0, 8'd0));
      send_request(make_request(OP_READ_CELL, 8'h00, 8'h00, 8'd0, 8'd0));

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0:       next_attr = 8'h00;
            1:       next_attr = 8'hFF;
            default: next_attr = BYTE_W'($urandom_range(0, 255));
         endcase
         write_text_attr(next_attr);
         steady_phase = (phase == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 3 && n == 10) long_hold_armed = 1'b1;
            send_request(random_request());
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests under %0d print attribute values; %0d responses checked.",
               requests_sent, PHASES + 1, response_count);
      $display("Covered control characters, cursor clamping, off-screen reads, clears and %0d scrolls.",
               scroll_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("text_console_writer test passed");
      end else begin
         $display("text_console_writer test failed");
      end
      $finish;
   end

endmodule
